// File: hw/rtl/spcq_pkg.sv
package spcq_pkg;

    localparam int QUEUE_DEPTH      = 16;
    localparam int PRIORITY_CLASSES = 5;
    localparam int TICKET_BITS      = 16;

    localparam int NUM_CLASSES  = PRIORITY_CLASSES + 1;
    localparam int COMMON_IDX   = PRIORITY_CLASSES;
    localparam int PTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int QIDX_W       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

    localparam int OPCODE_W     = 2;
    localparam int CLASS_IN_W   = 4;
    localparam int CLASS_OUT_W  = 3;
    localparam int STATUS_W     = 2;
    localparam int SVC_W        = 4;
    localparam int DOC_W        = 3;
    localparam int TAG_W        = 16;
    localparam int TICKET_OUT_W = 16;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ENQUEUE    = 2'd0,
        OP_DEQ_PRIO   = 2'd1,
        OP_DEQ_COMMON = 2'd2,
        OP_CLEAR      = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [TICKET_BITS-1:0] tkt;
        logic [SVC_W-1:0]       svc;
        logic [DOC_W-1:0]       doc;
        logic [TAG_W-1:0]       tag;
    } t_entry;

    // Between the decode stage and the result register
    typedef struct packed {
        t_status                status;
        logic [CLASS_OUT_W-1:0] cls;
        logic [TICKET_BITS-1:0] tkt;
        logic                   pop;
    } t_stage;

endpackage

// File: hw/rtl/strict_priority_class_queues.sv
// Strict-priority queue set: five priority classes and one common class, each a FIFO
// of QUEUE_DEPTH entries held in one on-chip entry memory.
// Input channel (i_valid / o_ready) carries one operation per transaction: enqueue,
// dequeue by priority, dequeue from the common class only, or clear all.
// Output channel (o_valid / i_ready) returns exactly one result per operation:
// status, class, ticket and, for a pop, the stored service time, doctor code and tag.
// The accepting edge updates counts and pointers and performs the memory write or head
// read; the result register takes the registered read data as the decode stage moves on.
// Throughput is one operation per cycle while results are taken; the entry memory has
// one write and one read port, and each operation uses at most one of them.
// A stalled receiver holds the result register; one more operation can wait in the
// decode stage, after which o_ready drops until the result is taken.
// Reset (synchronous, active low) empties every class and drops pending results.
// Memory contents are not cleared; an entry is read only after it has been written.
module strict_priority_class_queues
    import spcq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [OPCODE_W-1:0]    i_opcode,
    input  logic [CLASS_IN_W-1:0]  i_queue_class,
    input  logic [SVC_W-1:0]       i_service_time,
    input  logic [DOC_W-1:0]       i_doctor_code,
    input  logic [TAG_W-1:0]       i_record_tag,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [STATUS_W-1:0]    o_op_status,
    output logic [CLASS_OUT_W-1:0] o_served_class,
    output logic [TICKET_OUT_W-1:0] o_ticket,
    output logic [SVC_W-1:0]       o_out_service_time,
    output logic [DOC_W-1:0]       o_out_doctor_code,
    output logic [TAG_W-1:0]       o_out_record_tag
);

    localparam logic [TICKET_BITS-1:0] TKT_ONE = TICKET_BITS'(1);
    localparam logic [TICKET_BITS-1:0] TKT_MAX = {TICKET_BITS{1'b1}};
    localparam logic [CNT_W-1:0]       CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0]       PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    // Queue state
    logic [CNT_W-1:0]       r_count [NUM_CLASSES];
    logic [PTR_W-1:0]       r_head  [NUM_CLASSES];
    logic [PTR_W-1:0]       r_tail  [NUM_CLASSES];
    logic [TICKET_BITS-1:0] r_last  [NUM_CLASSES];
    logic [CNT_W-1:0]       n_count [NUM_CLASSES];
    logic [PTR_W-1:0]       n_head  [NUM_CLASSES];
    logic [PTR_W-1:0]       n_tail  [NUM_CLASSES];
    logic [TICKET_BITS-1:0] n_last  [NUM_CLASSES];

    t_entry                 r_mem [NUM_CLASSES][QUEUE_DEPTH];
    t_entry                 r_rd_data;

    logic                   r_s1_valid;
    t_stage                 r_s1;
    t_stage                 n_s1;

    logic                   r_o_valid;
    logic [STATUS_W-1:0]    r_status;
    logic [CLASS_OUT_W-1:0] r_cls;
    logic [TICKET_BITS-1:0] r_tkt;
    logic [SVC_W-1:0]       r_svc;
    logic [DOC_W-1:0]       r_doc;
    logic [TAG_W-1:0]       r_tag;

    logic                   w_in_acc;
    logic                   w_s1_move;
    logic                   w_wr_en;
    logic                   w_rd_en;
    logic [QIDX_W-1:0]      w_enq_q;
    logic [QIDX_W-1:0]      w_pop_q;
    logic [QIDX_W-1:0]      w_pick_q;
    logic                   w_pick_found;
    logic [TICKET_BITS-1:0] w_new_tkt;
    t_entry                 w_wr_entry;

    assign w_s1_move = r_s1_valid && (!r_o_valid || i_ready);
    assign o_ready   = !r_s1_valid || w_s1_move;
    assign w_in_acc  = i_valid && o_ready;

    // Lowest-numbered non-empty class
    always_comb begin
        w_pick_q     = QIDX_W'(0);
        w_pick_found = 1'b0;
        for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
            if (r_count[i] != '0) begin
                w_pick_q     = QIDX_W'(i);
                w_pick_found = 1'b1;
            end
        end
    end

    always_comb begin
        if (i_queue_class >= CLASS_IN_W'(1) &&
            i_queue_class <= CLASS_IN_W'(PRIORITY_CLASSES)) begin
            w_enq_q = QIDX_W'(i_queue_class - CLASS_IN_W'(1));
        end else begin
            w_enq_q = QIDX_W'(COMMON_IDX);
        end
    end

    always_comb begin
        if (r_count[w_enq_q] == '0 || r_last[w_enq_q] == TKT_MAX) begin
            w_new_tkt = TKT_ONE;
        end else begin
            w_new_tkt = r_last[w_enq_q] + TKT_ONE;
        end
    end

    assign w_wr_entry = '{tkt: w_new_tkt, svc: i_service_time,
                          doc: i_doctor_code, tag: i_record_tag};

    always_comb begin
        n_count = r_count;
        n_head  = r_head;
        n_tail  = r_tail;
        n_last  = r_last;
        n_s1    = '{status: ST_DONE, cls: '0, tkt: '0, pop: 1'b0};
        w_wr_en = 1'b0;
        w_rd_en = 1'b0;
        w_pop_q = w_pick_q;

        unique case (t_opcode'(i_opcode)) inside
            OP_ENQUEUE: begin
                if (r_count[w_enq_q] == CNT_FULL) begin
                    n_s1.status = ST_FULL;
                end else begin
                    w_wr_en          = 1'b1;
                    n_tail[w_enq_q]  = (r_tail[w_enq_q] == PTR_LAST) ? '0
                                       : r_tail[w_enq_q] + PTR_W'(1);
                    n_count[w_enq_q] = r_count[w_enq_q] + CNT_W'(1);
                    n_last[w_enq_q]  = w_new_tkt;
                    n_s1.cls         = CLASS_OUT_W'(w_enq_q) + CLASS_OUT_W'(1);
                    n_s1.tkt         = w_new_tkt;
                end
            end
            OP_DEQ_PRIO, OP_DEQ_COMMON: begin
                if (t_opcode'(i_opcode) == OP_DEQ_COMMON) begin
                    w_pop_q = QIDX_W'(COMMON_IDX);
                end
                if (r_count[w_pop_q] == '0) begin
                    n_s1.status = ST_EMPTY;
                end else begin
                    w_rd_en          = 1'b1;
                    n_head[w_pop_q]  = (r_head[w_pop_q] == PTR_LAST) ? '0
                                       : r_head[w_pop_q] + PTR_W'(1);
                    n_count[w_pop_q] = r_count[w_pop_q] - CNT_W'(1);
                    n_s1.cls         = CLASS_OUT_W'(w_pop_q) + CLASS_OUT_W'(1);
                    n_s1.pop         = 1'b1;
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < NUM_CLASSES; i++) begin
                    n_count[i] = '0;
                    n_head[i]  = '0;
                    n_tail[i]  = '0;
                    n_last[i]  = '0;
                end
            end
            default: begin
                n_s1 = '{status: ST_DONE, cls: '0, tkt: '0, pop: 1'b0};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_count[i] <= '0;
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_last[i]  <= '0;
            end
        end else if (w_in_acc) begin
            r_count <= n_count;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_last  <= n_last;
        end
    end

    // Entry memory: one write port at the tail, one registered read port at the head
    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_wr_en) begin
            r_mem[w_enq_q][r_tail[w_enq_q]] <= w_wr_entry;
        end
        if (w_in_acc && w_rd_en) begin
            r_rd_data <= r_mem[w_pop_q][r_head[w_pop_q]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1 <= n_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_status <= r_s1.status;
            r_cls    <= r_s1.cls;
            if (r_s1.pop) begin
                r_tkt <= r_rd_data.tkt;
                r_svc <= r_rd_data.svc;
                r_doc <= r_rd_data.doc;
                r_tag <= r_rd_data.tag;
            end else begin
                r_tkt <= r_s1.tkt;
                r_svc <= '0;
                r_doc <= '0;
                r_tag <= '0;
            end
        end
    end

    assign o_valid            = r_o_valid;
    assign o_op_status        = r_status;
    assign o_served_class     = r_cls;
    assign o_ticket           = TICKET_OUT_W'(r_tkt);
    assign o_out_service_time = r_svc;
    assign o_out_doctor_code  = r_doc;
    assign o_out_record_tag   = r_tag;

`ifndef SYNTHESIS
    for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_chk
        a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_count[g] <= CNT_FULL)
            else $error("class count exceeds queue depth");
    end

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_o_valid && !i_ready) |-> !o_ready)
        else $error("decode stage overwritten while result stalled");

    a_common_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_opcode == OP_DEQ_COMMON && r_count[COMMON_IDX] == '0)
        |=> (r_s1.status == ST_EMPTY && !r_s1.pop))
        else $error("pop from empty common class not flagged");

    a_clear_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_opcode == OP_CLEAR)
        |=> (r_count[0] == '0 && r_count[COMMON_IDX] == '0 && r_s1.status == ST_DONE))
        else $error("clear left a class non-empty");
`endif

endmodule

// File: tb/strict_priority_class_queues_test.sv
`timescale 1ns / 100ps

module strict_priority_class_queues_test;
    import spcq_pkg::*;

    localparam int RANDOM_OPS     = 1840;
    localparam int IDLE_PCT       = 16;
    localparam int RX_HOLD_CYCLES = 64;
    localparam int STALL_LIMIT    = 2000;

    typedef struct packed {
        t_status                 status;
        logic [CLASS_OUT_W-1:0]  cls;
        logic [TICKET_OUT_W-1:0] tkt;
        logic [SVC_W-1:0]        svc;
        logic [DOC_W-1:0]        doc;
        logic [TAG_W-1:0]        tag;
    } result_t;

    typedef struct {
        t_opcode                op;
        logic [CLASS_IN_W-1:0]  qc;
        logic [SVC_W-1:0]       svc;
        logic [DOC_W-1:0]       doc;
        logic [TAG_W-1:0]       tag;
        bit                     known;
        result_t                want;
    } op_row_t;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic [OPCODE_W-1:0]     i_opcode;
    logic [CLASS_IN_W-1:0]   i_queue_class;
    logic [SVC_W-1:0]        i_service_time;
    logic [DOC_W-1:0]        i_doctor_code;
    logic [TAG_W-1:0]        i_record_tag;
    logic                    o_valid;
    logic                    i_ready;
    logic [STATUS_W-1:0]     o_op_status;
    logic [CLASS_OUT_W-1:0]  o_served_class;
    logic [TICKET_OUT_W-1:0] o_ticket;
    logic [SVC_W-1:0]        o_out_service_time;
    logic [DOC_W-1:0]        o_out_doctor_code;
    logic [TAG_W-1:0]        o_out_record_tag;

    // Shadow copy of the queue state
    t_entry                 slot_mem    [NUM_CLASSES][QUEUE_DEPTH];
    int                     head_idx    [NUM_CLASSES];
    int                     tail_idx    [NUM_CLASSES];
    int                     fill_cnt    [NUM_CLASSES];
    logic [TICKET_BITS-1:0] tail_ticket [NUM_CLASSES];

    result_t  expected_results[$];
    op_row_t  directed_rows[$];
    bit       known_on;
    result_t  known_result;
    bit       idling_on;
    bit       hold_request;
    int       error_count;
    int       quiet_cycles;

    strict_priority_class_queues dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_opcode           (i_opcode),
        .i_queue_class      (i_queue_class),
        .i_service_time     (i_service_time),
        .i_doctor_code      (i_doctor_code),
        .i_record_tag       (i_record_tag),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_op_status        (o_op_status),
        .o_served_class     (o_served_class),
        .o_ticket           (o_ticket),
        .o_out_service_time (o_out_service_time),
        .o_out_doctor_code  (o_out_doctor_code),
        .o_out_record_tag   (o_out_record_tag)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void empty_all_classes();
        for (int c = 0; c < NUM_CLASSES; c++) begin
            head_idx[c]    = 0;
            tail_idx[c]    = 0;
            fill_cnt[c]    = 0;
            tail_ticket[c] = '0;
        end
    endfunction

    function automatic result_t outcome(t_status st, int cls, int tkt, int svc, int doc,
                                        int tag);
        result_t r;
        r.status = st;
        r.cls    = CLASS_OUT_W'(cls);
        r.tkt    = TICKET_OUT_W'(tkt);
        r.svc    = SVC_W'(svc);
        r.doc    = DOC_W'(doc);
        r.tag    = TAG_W'(tag);
        return r;
    endfunction

    // Apply one operation to the shadow state and return the result it must produce
    function automatic result_t serve_operation(t_opcode op, logic [CLASS_IN_W-1:0] qc,
                                                logic [SVC_W-1:0] svc,
                                                logic [DOC_W-1:0] doc,
                                                logic [TAG_W-1:0] tag);
        result_t                r;
        int                     q;
        logic [TICKET_BITS:0]   t;
        t_entry                 e;
        r = '0;
        r.status = ST_DONE;
        case (op) inside
            OP_ENQUEUE: begin
                q = (qc >= 1 && qc <= PRIORITY_CLASSES) ? int'(qc) - 1 : COMMON_IDX;
                if (fill_cnt[q] >= QUEUE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    if (fill_cnt[q] == 0) begin
                        t = 1;
                    end else begin
                        t = {1'b0, tail_ticket[q]} + 1'b1;
                        // wrap past the top ticket back to 1
                        if (t[TICKET_BITS]) begin
                            t = 1;
                        end
                    end
                    e.tkt = t[TICKET_BITS-1:0];
                    e.svc = svc;
                    e.doc = doc;
                    e.tag = tag;
                    slot_mem[q][tail_idx[q]] = e;
                    tail_idx[q]    = (tail_idx[q] + 1) % QUEUE_DEPTH;
                    fill_cnt[q]    = fill_cnt[q] + 1;
                    tail_ticket[q] = t[TICKET_BITS-1:0];
                    r.cls = CLASS_OUT_W'(q + 1);
                    r.tkt = TICKET_OUT_W'(t[TICKET_BITS-1:0]);
                end
            end
            OP_DEQ_PRIO, OP_DEQ_COMMON: begin
                q = -1;
                if (op == OP_DEQ_COMMON) begin
                    if (fill_cnt[COMMON_IDX] != 0) begin
                        q = COMMON_IDX;
                    end
                end else begin
                    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
                        if (fill_cnt[c] != 0) begin
                            q = c;
                        end
                    end
                end
                if (q < 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    e = slot_mem[q][head_idx[q]];
                    head_idx[q] = (head_idx[q] + 1) % QUEUE_DEPTH;
                    fill_cnt[q] = fill_cnt[q] - 1;
                    r.cls = CLASS_OUT_W'(q + 1);
                    r.tkt = TICKET_OUT_W'(e.tkt);
                    r.svc = e.svc;
                    r.doc = e.doc;
                    r.tag = e.tag;
                end
            end
            default: begin
                empty_all_classes();
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
        error_count++;
        $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    // Monitor: compare the result transaction first, then predict the operation transaction
    always @(posedge i_clk) begin
        result_t got;
        result_t want;
        result_t predicted;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                got.status = t_status'(o_op_status);
                got.cls    = o_served_class;
                got.tkt    = o_ticket;
                got.svc    = o_out_service_time;
                got.doc    = o_out_doctor_code;
                got.tag    = o_out_record_tag;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing pending", 0, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status) begin
                        report_mismatch("op_status", want.status, got.status);
                    end
                    if (got.cls !== want.cls) begin
                        report_mismatch("served_class", want.cls, got.cls);
                    end
                    if (got.tkt !== want.tkt) begin
                        report_mismatch("ticket", want.tkt, got.tkt);
                    end
                    if (got.svc !== want.svc) begin
                        report_mismatch("out_service_time", want.svc, got.svc);
                    end
                    if (got.doc !== want.doc) begin
                        report_mismatch("out_doctor_code", want.doc, got.doc);
                    end
                    if (got.tag !== want.tag) begin
                        report_mismatch("out_record_tag", want.tag, got.tag);
                    end
                end
            end
            if (i_valid && o_ready) begin
                predicted = serve_operation(t_opcode'(i_opcode), i_queue_class,
                                            i_service_time, i_doctor_code, i_record_tag);
                expected_results.push_back(known_on ? known_result : predicted);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: random back-pressure, plus one long hold on request
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(negedge i_clk);
                hold_request = 1'b0;
            end else if (idling_on && $urandom_range(0, 99) < IDLE_PCT) begin
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Call and return at a falling edge; hold valid and payload until the transaction
    task automatic offer(t_opcode op, logic [CLASS_IN_W-1:0] qc, logic [SVC_W-1:0] svc,
                         logic [DOC_W-1:0] doc, logic [TAG_W-1:0] tag, bit known,
                         result_t want);
        while (idling_on && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_opcode       <= op;
        i_queue_class  <= qc;
        i_service_time <= svc;
        i_doctor_code  <= doc;
        i_record_tag   <= tag;
        known_on     = known;
        known_result = want;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic offer_op(t_opcode op, logic [CLASS_IN_W-1:0] qc);
        offer(op, qc, SVC_W'($urandom_range(0, (1 << SVC_W) - 1)),
              DOC_W'($urandom_range(0, (1 << DOC_W) - 1)), TAG_W'($urandom()), 1'b0, '0);
    endtask

    task automatic wait_results_drained();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic add_row(t_opcode op, int qc, int svc, int doc, int tag);
        op_row_t row;
        row.op    = op;
        row.qc    = CLASS_IN_W'(qc);
        row.svc   = SVC_W'(svc);
        row.doc   = DOC_W'(doc);
        row.tag   = TAG_W'(tag);
        row.known = 1'b0;
        row.want  = '0;
        directed_rows.push_back(row);
    endtask

    task automatic add_known_row(t_opcode op, int qc, int svc, int doc, int tag,
                                 result_t want);
        add_row(op, qc, svc, doc, tag);
        directed_rows[directed_rows.size() - 1].known = 1'b1;
        directed_rows[directed_rows.size() - 1].want  = want;
    endtask

    initial begin
        int                    sent;
        int                    pick;
        int                    n;
        bit                    hold_done;
        logic [CLASS_IN_W-1:0] qc;
        op_row_t               row;

        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_opcode       = OP_ENQUEUE;
        i_queue_class  = '0;
        i_service_time = '0;
        i_doctor_code  = '0;
        i_record_tag   = '0;
        known_on       = 1'b0;
        known_result   = '0;
        idling_on      = 1'b1;
        hold_request   = 1'b0;
        error_count    = 0;
        quiet_cycles   = 0;
        hold_done      = 1'b0;
        empty_all_classes();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty pops and clear right after reset
        add_known_row(OP_DEQ_PRIO,   0, 0, 0, 0, outcome(ST_EMPTY, 0, 0, 0, 0, 0));
        add_known_row(OP_DEQ_COMMON, 0, 0, 0, 0, outcome(ST_EMPTY, 0, 0, 0, 0, 0));
        add_known_row(OP_CLEAR,      0, 0, 0, 0, outcome(ST_DONE, 0, 0, 0, 0, 0));
        // Extremes of the payload; class codes outside 1..5 land in the common class
        add_known_row(OP_ENQUEUE, 0, 15, 7, 16'hFFFF,
                      outcome(ST_DONE, COMMON_IDX + 1, 1, 0, 0, 0));
        add_known_row(OP_ENQUEUE, 1, 0, 0, 0, outcome(ST_DONE, 1, 1, 0, 0, 0));
        add_known_row(OP_ENQUEUE, 5, 10, 5, 16'h8001, outcome(ST_DONE, 5, 1, 0, 0, 0));
        add_known_row(OP_ENQUEUE, 15, 1, 3, 16'h7FFE,
                      outcome(ST_DONE, COMMON_IDX + 1, 2, 0, 0, 0));
        add_row(OP_ENQUEUE, 6, 4, 1, 16'h1234);
        add_row(OP_ENQUEUE, 7, 8, 6, 16'h5A5A);
        add_row(OP_ENQUEUE, 1, 9, 2, 16'hAAAA);
        add_row(OP_ENQUEUE, 3, 2, 4, 16'h5555);
        // Common-only pop with priority classes still loaded
        add_known_row(OP_DEQ_COMMON, 0, 0, 0, 0,
                      outcome(ST_DONE, COMMON_IDX + 1, 1, 15, 7, 16'hFFFF));
        add_row(OP_DEQ_PRIO,   0, 0, 0, 0);
        add_row(OP_DEQ_PRIO,   0, 0, 0, 0);
        add_row(OP_DEQ_PRIO,   0, 0, 0, 0);
        add_row(OP_DEQ_COMMON, 0, 0, 0, 0);
        add_row(OP_DEQ_PRIO,   0, 0, 0, 0);
        add_row(OP_DEQ_PRIO,   0, 0, 0, 0);
        add_row(OP_DEQ_PRIO,   0, 0, 0, 0);
        add_known_row(OP_DEQ_PRIO, 0, 0, 0, 0, outcome(ST_EMPTY, 0, 0, 0, 0, 0));
        add_row(OP_ENQUEUE, 2, 3, 3, 16'h0F0F);
        add_row(OP_ENQUEUE, 4, 6, 0, 16'hF0F0);
        // Clear with entries live, then tickets restart at 1
        add_known_row(OP_CLEAR,    9, 9, 5, 16'hFFFF, outcome(ST_DONE, 0, 0, 0, 0, 0));
        add_known_row(OP_DEQ_PRIO, 0, 0, 0, 0, outcome(ST_EMPTY, 0, 0, 0, 0, 0));
        add_known_row(OP_ENQUEUE, 4, 1, 1, 1, outcome(ST_DONE, 4, 1, 0, 0, 0));

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            offer(row.op, row.qc, row.svc, row.doc, row.tag, row.known, row.want);
        end
        wait_results_drained();

        // Bursts fill classes to full and wrap their pointers; drains empty them again
        sent = 0;
        while (sent < RANDOM_OPS) begin
            if (!hold_done && sent >= 500) begin
                hold_done = 1'b1;
                wait_results_drained();
                hold_request = 1'b1;
            end
            idling_on = !(sent >= 1000 && sent < 1300);
            pick = $urandom_range(0, 99);
            if (pick < 42) begin
                qc = CLASS_IN_W'($urandom_range(0, (1 << CLASS_IN_W) - 1));
                n  = $urandom_range(6, 20);
                repeat (n) offer_op(OP_ENQUEUE, qc);
                sent += n;
            end else if (pick < 80) begin
                n = $urandom_range(4, 24);
                repeat (n) begin
                    offer_op(t_opcode'(($urandom_range(0, 99) < 70) ? OP_DEQ_PRIO
                                                                      : OP_DEQ_COMMON),
                             CLASS_IN_W'($urandom()));
                end
                sent += n;
            end else if (pick < 97) begin
                n = $urandom_range(1, 8);
                repeat (n) begin
                    pick = $urandom_range(0, 99);
                    offer_op(t_opcode'(pick < 40 ? OP_ENQUEUE : pick < 70 ? OP_DEQ_PRIO :
                                       pick < 95 ? OP_DEQ_COMMON : OP_CLEAR),
                             CLASS_IN_W'($urandom()));
                end
                sent += n;
            end else begin
                offer_op(OP_CLEAR, CLASS_IN_W'($urandom()));
                sent++;
            end
        end

        idling_on = 1'b1;
        repeat (40) offer_op(OP_DEQ_PRIO, CLASS_IN_W'($urandom()));

        wait_results_drained();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
